@@ rtl/core/smcs_pkg.sv @@
`timescale 1ns / 1ps
package smcs_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_START_BYTE     = 8'd0;
  localparam logic [7:0] REG_DEVICE_NUMBER  = 8'd1;
  localparam logic [7:0] REG_MOTOR_A_CODE   = 8'd2;
  localparam logic [7:0] REG_MOTOR_B_CODE   = 8'd3;
  localparam logic [7:0] REG_FORWARD_CODE   = 8'd4;
  localparam logic [7:0] REG_REVERSE_CODE   = 8'd5;
  localparam logic [7:0] REG_MAX_SPEED_CODE = 8'd6;
  localparam logic [7:0] REG_BIT_PERIOD     = 8'd7;

  // Item kinds and motor selects
  localparam logic       FUNC_CMD  = 1'b0;
  localparam logic       FUNC_TICK = 1'b1;
  localparam logic [1:0] SEL_A     = 2'd0;
  localparam logic [1:0] SEL_B     = 2'd1;

  // Speed scaling: divide by 100 as multiply by 5243 then shift by 19,
  // exact for products below 43690 (largest product is 100 * 127).
  localparam logic [6:0]  SPEED_FULL  = 7'd100;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // Bit positions inside a frame: 0 start, 1..8 data, 9..10 stop
  localparam logic [3:0] BIT_START     = 4'd0;
  localparam logic [3:0] BIT_LAST_DATA = 4'd8;
  localparam logic [3:0] BIT_LAST_STOP = 4'd10;
  localparam logic [1:0] BYTE_LAST     = 2'd3;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  device_number;
    logic [7:0]  motor_a_code;
    logic [7:0]  motor_b_code;
    logic [7:0]  forward_code;
    logic [7:0]  reverse_code;
    logic [6:0]  max_speed_code;
    logic [15:0] bit_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_stat_t;

endpackage

@@ rtl/core/smcs_cfg.sv @@
`timescale 1ns / 1ps
module smcs_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [7:0]        wr_index,
  input  logic [15:0]       wr_data,
  output smcs_pkg::cfg_t    cfg_q
);
  import smcs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_START_BYTE:     cfg_nxt.start_byte       = wr_data[7:0];
        REG_DEVICE_NUMBER:  cfg_nxt.device_number    = wr_data[7:0];
        REG_MOTOR_A_CODE:   cfg_nxt.motor_a_code     = wr_data[7:0];
        REG_MOTOR_B_CODE:   cfg_nxt.motor_b_code     = wr_data[7:0];
        REG_FORWARD_CODE:   cfg_nxt.forward_code     = wr_data[7:0];
        REG_REVERSE_CODE:   cfg_nxt.reverse_code     = wr_data[7:0];
        REG_MAX_SPEED_CODE: cfg_nxt.max_speed_code   = wr_data[6:0];
        REG_BIT_PERIOD:     cfg_nxt.bit_period_ticks = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte       <= 8'd170;
      cfg_r.device_number    <= 8'd0;
      cfg_r.motor_a_code     <= 8'd0;
      cfg_r.motor_b_code     <= 8'd0;
      cfg_r.forward_code     <= 8'd0;
      cfg_r.reverse_code     <= 8'd1;
      cfg_r.max_speed_code   <= 7'd127;
      cfg_r.bit_period_ticks <= 16'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_q = cfg_r;

endmodule

@@ rtl/core/smcs_tx.sv @@
`timescale 1ns / 1ps
module smcs_tx (
  input  logic                clk,
  input  logic                rst_n,
  input  smcs_pkg::cfg_t      cfg_q,
  input  logic                item_en,
  input  logic                item_func,
  input  logic [1:0]          item_sel,
  input  logic signed [15:0]  item_speed,
  output logic                busy_now,
  output smcs_pkg::tx_stat_t  stat_nxt
);
  import smcs_pkg::*;

  logic [31:0] frame_r,  frame_nxt;
  logic [1:0]  byte_r,   byte_nxt;
  logic [3:0]  bit_r,    bit_nxt;
  logic [15:0] tick_r,   tick_nxt;
  logic        line_r,   line_nxt;
  logic        busy_r,   busy_nxt;
  logic        pend_r,   pend_nxt;
  logic [13:0] prod_r,   prod_nxt;

  logic [15:0] abs_val;
  logic        go_rev;
  logic [6:0]  mag;
  logic [7:0]  motor_code;
  logic [7:0]  dir_code;
  logic [15:0] period;
  logic [15:0] tick_sum;
  logic [26:0] scaled;

  function automatic logic level_for_bit(input logic [31:0] frame,
                                         input logic [1:0]  bsel,
                                         input logic [3:0]  bpos);
    logic [7:0] cur;
    logic       lvl;
    cur = frame[{bsel, 3'b000} +: 8];
    if (bpos == BIT_START) begin
      lvl = 1'b0;
    end else if (bpos <= BIT_LAST_DATA) begin
      lvl = cur[3'(bpos - 4'd1)];
    end else begin
      lvl = 1'b1;
    end
    return lvl;
  endfunction

  // Command decode: motor A flips the sign, clamp magnitude to full speed
  always_comb begin
    abs_val    = item_speed[15] ? (~item_speed + 16'd1) : item_speed;
    go_rev     = (item_sel == SEL_A) ? (!item_speed[15] && (item_speed != 16'sd0))
                                     : item_speed[15];
    mag        = (abs_val > {9'd0, SPEED_FULL}) ? SPEED_FULL : abs_val[6:0];
    motor_code = (item_sel == SEL_A) ? cfg_q.motor_a_code : cfg_q.motor_b_code;
    dir_code   = go_rev ? cfg_q.reverse_code : cfg_q.forward_code;
    period     = (cfg_q.bit_period_ticks == 16'd0) ? 16'd1 : cfg_q.bit_period_ticks;
    tick_sum   = tick_r + 16'd1;
    scaled     = {13'd0, prod_r} * {14'd0, RECIP_100};
  end

  always_comb begin
    frame_nxt = frame_r;
    byte_nxt  = byte_r;
    bit_nxt   = bit_r;
    tick_nxt  = tick_r;
    line_nxt  = line_r;
    busy_nxt  = busy_r;
    pend_nxt  = 1'b0;
    prod_nxt  = prod_r;

    // Finish the speed byte in the cycle after the command is taken
    if (pend_r) begin
      frame_nxt[31:24] = {1'b0, scaled[RECIP_SHIFT +: 7]};
    end

    if (item_en) begin
      if (item_func == FUNC_CMD) begin
        if (!busy_r && (item_sel == SEL_A || item_sel == SEL_B)) begin
          frame_nxt[23:0] = {motor_code | dir_code, cfg_q.device_number,
                             cfg_q.start_byte};
          prod_nxt = {7'd0, mag} * {7'd0, cfg_q.max_speed_code};
          pend_nxt = 1'b1;
          byte_nxt = 2'd0;
          bit_nxt  = BIT_START;
          tick_nxt = 16'd0;
          busy_nxt = 1'b1;
          line_nxt = 1'b0;
        end
      end else if (busy_r) begin
        tick_nxt = tick_sum;
        if (tick_sum >= period) begin
          tick_nxt = 16'd0;
          if (bit_r >= BIT_LAST_STOP) begin
            bit_nxt = BIT_START;
            if (byte_r == BYTE_LAST) begin
              byte_nxt = 2'd0;
              busy_nxt = 1'b0;
            end else begin
              byte_nxt = byte_r + 2'd1;
            end
          end else begin
            bit_nxt = bit_r + 4'd1;
          end
          line_nxt = busy_nxt ? level_for_bit(frame_r, byte_nxt, bit_nxt) : 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= 32'd0;
      byte_r  <= 2'd0;
      bit_r   <= BIT_START;
      tick_r  <= 16'd0;
      line_r  <= 1'b1;
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      frame_r <= frame_nxt;
      byte_r  <= byte_nxt;
      bit_r   <= bit_nxt;
      tick_r  <= tick_nxt;
      line_r  <= line_nxt;
      busy_r  <= busy_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign busy_now      = busy_r;
  assign stat_nxt.line = line_nxt;
  assign stat_nxt.busy = busy_nxt;

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> line_r)
    else $error("line low while idle");

  a_bit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BIT_LAST_STOP)
    else $error("bit position beyond last stop bit");

  a_speed_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (byte_r == 2'd0 && busy_r))
    else $error("speed byte still pending past first byte");

endmodule

@@ rtl/core/serial_motor_command_sender.sv @@
`timescale 1ns / 1ps
// Four-byte motor command sender over an 8N2 serial line. Each input beat is
// either a command (tuser = 0: motor select A/B plus signed speed) or a time
// tick (tuser = 1). A command taken while idle builds the frame (start byte,
// device number, motor code OR direction code, scaled 7-bit speed) and drives
// the start bit at once; every bit then lasts bit_period_ticks tick beats
// (zero acts as one). Every input beat yields exactly one output beat giving
// the line level and busy flag after that beat, plus a dropped flag for a
// command that arrived while busy. Rate: one beat per clock; a single output
// register holds the result, registered on acceptance, and a new input beat
// is taken whenever that register is empty or drains in the same cycle, so
// only a result left waiting holds off the input. The speed byte is finished
// in registered steps (magnitude times max_speed_code, then a reciprocal
// multiply for the divide by 100), hidden behind the first byte of the frame.
// Configuration writes are always ready; the user must keep them to idle
// periods only, which the block itself does not enforce.
module serial_motor_command_sender (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] motor_select, [17:2] dir_speed, rest zero
  input  logic        in_tuser,   // [0] func
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] line_level, [1] busy_res, [2] dropped, rest zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import smcs_pkg::*;

  cfg_t     cfg_q;
  tx_stat_t stat_nxt;
  logic     busy_now;
  logic     in_acc;
  logic     drop_now;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_data_r,  out_data_nxt;

  // Take a new beat whenever the result slot is empty or draining this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  smcs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_q    (cfg_q)
  );

  smcs_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_q      (cfg_q),
    .item_en    (in_acc),
    .item_func  (in_tuser),
    .item_sel   (in_tdata[1:0]),
    .item_speed (in_tdata[17:2]),
    .busy_now   (busy_now),
    .stat_nxt   (stat_nxt)
  );

  // Drop any command that lands mid-transmission
  assign drop_now = (in_tuser == FUNC_CMD) && busy_now;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {drop_now, stat_nxt.busy, stat_nxt.line};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

  a_drop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[2]) |-> out_data_r[1])
    else $error("dropped flag without busy");

  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == FUNC_CMD && !busy_now &&
     (in_tdata[1:0] == SEL_A || in_tdata[1:0] == SEL_B))
    |=> (out_valid_r && !out_data_r[0] && out_data_r[1] && !out_data_r[2]))
    else $error("accepted command did not start a frame");

  a_period_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == REG_BIT_PERIOD)
    |=> cfg_q.bit_period_ticks == $past(cfg_data))
    else $error("bit period write lost");

endmodule

@@ tb/serial_motor_command_checker.sv @@
`timescale 1ns / 1ps
module serial_motor_command_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] motor_select, [17:2] dir_speed, rest zero
  input  logic        in_tuser,   // [0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [0] line_level, [1] busy_res, [2] dropped, rest zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output logic        tx_busy,
  output int          frames_started,
  output int          busy_drops,
  output int          beats_checked
);
  import smcs_pkg::*;

  localparam int FULL_SPEED = 100;

  typedef struct packed {
    logic dropped;
    logic busy;
    logic line;
  } line_beat_t;

  cfg_t        regs;
  logic [31:0] frame;
  logic [1:0]  byte_sel;
  logic [3:0]  bit_pos;
  logic [15:0] tick_cnt;
  logic        line_q;
  logic        busy_q;
  line_beat_t  line_beats_q[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic level_now();
    logic [7:0] cur;
    cur = frame[byte_sel*8 +: 8];
    if (bit_pos == BIT_START) return 1'b0;
    if (bit_pos <= BIT_LAST_DATA) return cur[bit_pos - 4'd1];
    return 1'b1;
  endfunction

  task automatic apply_write(input logic [7:0] idx, input logic [15:0] val);
    case (idx)
      REG_START_BYTE:     regs.start_byte = val[7:0];
      REG_DEVICE_NUMBER:  regs.device_number = val[7:0];
      REG_MOTOR_A_CODE:   regs.motor_a_code = val[7:0];
      REG_MOTOR_B_CODE:   regs.motor_b_code = val[7:0];
      REG_FORWARD_CODE:   regs.forward_code = val[7:0];
      REG_REVERSE_CODE:   regs.reverse_code = val[7:0];
      REG_MAX_SPEED_CODE: regs.max_speed_code = val[6:0];
      REG_BIT_PERIOD:     regs.bit_period_ticks = val;
      default: ;
    endcase
  endtask

  // Advance the line state by one beat and give the line, busy and drop flags after it.
  task automatic advance_line(input logic func, input logic [1:0] sel,
                              input logic [15:0] raw, output line_beat_t res);
    logic signed [17:0] spd;
    logic [7:0]         dir_code;
    logic [7:0]         mot_code;
    logic [6:0]         mag;
    logic [13:0]        prod;
    logic [6:0]         speed_code;
    logic [15:0]        period;
    res.dropped = 1'b0;
    if (func == FUNC_CMD) begin
      if (busy_q) begin
        res.dropped = 1'b1;
        busy_drops++;
      end else if (sel == SEL_A || sel == SEL_B) begin
        spd = $signed(raw);
        // motor A is mounted mirrored
        if (sel == SEL_A) spd = -spd;
        dir_code = regs.forward_code;
        if (spd < 0) begin
          dir_code = regs.reverse_code;
          spd = -spd;
        end
        mag = (spd > FULL_SPEED) ? 7'(FULL_SPEED) : spd[6:0];
        prod = mag * regs.max_speed_code;
        speed_code = 7'(prod / FULL_SPEED);
        mot_code = (sel == SEL_A) ? regs.motor_a_code : regs.motor_b_code;
        frame = {1'b0, speed_code, mot_code | dir_code, regs.device_number, regs.start_byte};
        byte_sel = '0;
        bit_pos = BIT_START;
        tick_cnt = '0;
        busy_q = 1'b1;
        line_q = level_now();
        frames_started++;
      end
    end else if (busy_q) begin
      period = (regs.bit_period_ticks == 16'd0) ? 16'd1 : regs.bit_period_ticks;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= period) begin
        tick_cnt = '0;
        if (bit_pos >= BIT_LAST_STOP) begin
          bit_pos = BIT_START;
          if (byte_sel >= BYTE_LAST) begin
            byte_sel = '0;
            busy_q = 1'b0;
          end else begin
            byte_sel = byte_sel + 2'd1;
          end
        end else begin
          bit_pos = bit_pos + 4'd1;
        end
        line_q = busy_q ? level_now() : 1'b1;
      end
    end
    res.line = line_q;
    res.busy = busy_q;
  endtask

  always @(posedge clk) begin
    line_beat_t got;
    line_beat_t want;
    line_beat_t res;
    if (!rst_n) begin
      regs.start_byte = 8'd170;
      regs.device_number = 8'd0;
      regs.motor_a_code = 8'd0;
      regs.motor_b_code = 8'd0;
      regs.forward_code = 8'd0;
      regs.reverse_code = 8'd1;
      regs.max_speed_code = 7'd127;
      regs.bit_period_ticks = 16'd10;
      frame = '0;
      byte_sel = '0;
      bit_pos = BIT_START;
      tick_cnt = '0;
      line_q = 1'b1;
      busy_q = 1'b0;
      line_beats_q.delete();
      fail_count = 0;
      frames_started = 0;
      busy_drops = 0;
      beats_checked = 0;
    end else begin
      // the result of a beat is registered and leaves after it, so retire first
      if (out_tvalid && out_tready) begin
        got = out_tdata[2:0];
        if (line_beats_q.size() == 0) begin
          report_mismatch($sformatf("result beat %b with nothing expected", got));
        end else begin
          want = line_beats_q.pop_front();
          beats_checked++;
          if (got.line != want.line)
            report_mismatch($sformatf("line_level %b, want %b", got.line, want.line));
          if (got.busy != want.busy)
            report_mismatch($sformatf("busy_res %b, want %b", got.busy, want.busy));
          if (got.dropped != want.dropped)
            report_mismatch($sformatf("dropped %b, want %b", got.dropped, want.dropped));
        end
      end
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        advance_line(in_tuser, in_tdata[1:0], in_tdata[17:2], res);
        line_beats_q.push_back(res);
      end
    end
    pending <= line_beats_q.size();
    tx_busy <= busy_q;
  end

endmodule

@@ tb/tb_serial_motor_command_sender.sv @@
`timescale 1ns / 1ps
module tb_serial_motor_command_sender;
  import smcs_pkg::*;

  // indexes past the register file: writes there must change nothing
  localparam logic [7:0] REG_PAST_END  = REG_BIT_PERIOD + 8'd1;
  localparam logic [7:0] REG_INDEX_TOP = 8'hFF;
  localparam int FRAME_BITS     = 44;   // four bytes of eleven bits
  localparam int RANDOM_PHASES  = 3;
  localparam int CMDS_PER_PHASE = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [1:0] motor_select, [17:2] dir_speed, rest zero
  logic        in_tuser = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [0] line_level, [1] busy_res, [2] dropped, rest zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int   fail_count;
  int   pending;
  logic tx_busy;
  int   frames_started;
  int   busy_drops;
  int   beats_checked;

  logic gaps_on = 1'b1;   // random idling on both sides
  int   settings_loaded = 0;
  int   cur_period = 10;  // effective ticks per bit of the current setting

  initial begin
    forever #10 clk = ~clk;
  end

  serial_motor_command_sender i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  serial_motor_command_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .tx_busy        (tx_busy),
    .frames_started (frames_started),
    .busy_drops     (busy_drops),
    .beats_checked  (beats_checked)
  );

  // Stall the result side at random; hold ready high while idling is off.
  always @(posedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= 28);
  end

  // Offer one beat and return at the edge that takes it. Valid stays high on
  // return so back-to-back beats never lower and raise it in one step.
  task automatic push_item(input logic func, input logic [1:0] sel, input logic [15:0] spd);
    if (gaps_on) begin
      while ($urandom_range(99) < 28) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {6'd0, spd, sel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Ticks carry random select and speed bits: the block must ignore them.
  task automatic push_ticks(input int n);
    repeat (n) push_item(FUNC_TICK, 2'($urandom), 16'($urandom));
  endtask

  // Tick until the frame in flight has fully gone out. The busy flag seen
  // here lags one beat, so always send at least one tick.
  task automatic finish_frame();
    do push_item(FUNC_TICK, 2'($urandom), 16'($urandom)); while (tx_busy);
  endtask

  task automatic hold_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait until every result beat has been taken.
  task automatic wait_results();
    hold_input();
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load a full register setting while idle. Unused upper data bits are
  // random, and two writes to indexes past the end follow the real ones.
  task automatic load_config(input cfg_t c);
    wait_results();
    write_reg(REG_START_BYTE,     {8'($urandom), c.start_byte});
    write_reg(REG_DEVICE_NUMBER,  {8'($urandom), c.device_number});
    write_reg(REG_MOTOR_A_CODE,   {8'($urandom), c.motor_a_code});
    write_reg(REG_MOTOR_B_CODE,   {8'($urandom), c.motor_b_code});
    write_reg(REG_FORWARD_CODE,   {8'($urandom), c.forward_code});
    write_reg(REG_REVERSE_CODE,   {8'($urandom), c.reverse_code});
    write_reg(REG_MAX_SPEED_CODE, {9'($urandom), c.max_speed_code});
    write_reg(REG_BIT_PERIOD,     c.bit_period_ticks);
    write_reg(REG_PAST_END,       16'($urandom));
    write_reg(REG_INDEX_TOP,      16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_period = (c.bit_period_ticks == 16'd0) ? 1 : int'(c.bit_period_ticks);
    settings_loaded++;
  endtask

  // Mostly small speeds around the clamp, some full-range, some at the rails.
  function automatic logic [15:0] random_speed();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 16'(int'($urandom_range(240)) - 120);
      6, 7:             return 16'($urandom);
      8:                return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default:          return 16'(int'($urandom_range(3)) - 1 + ($urandom_range(1) ? 100 : -100));
    endcase
  endfunction

  function automatic logic [1:0] random_select();
    int r;
    r = $urandom_range(99);
    if (r < 45) return SEL_A;
    if (r < 90) return SEL_B;
    return 2'($urandom_range(2, 3));
  endfunction

  // One command per round, then either the whole frame, part of it (so the
  // next command lands on a busy line), or almost nothing.
  task automatic run_phase(input int ncmds, input int pause_at);
    int m;
    for (int k = 0; k < ncmds; k++) begin
      if (k == pause_at) wait_results();
      push_item(FUNC_CMD, random_select(), random_speed());
      m = $urandom_range(99);
      if (m < 55) begin
        finish_frame();
        push_ticks($urandom_range(3));
      end else if (m < 85) begin
        push_ticks($urandom_range(FRAME_BITS * cur_period));
      end else begin
        push_ticks($urandom_range(3));
      end
    end
    finish_frame();
  endtask

  initial begin
    cfg_t        c;
    logic [15:0] corner_speeds [4];
    corner_speeds = '{16'h8000, 16'h8000, 16'd101, 16'hFF9C};

    // Hold reset, then release it once for good.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick and unknown select under the reset setting, then
    // one frame with every register but the bit period at its reset value.
    push_ticks(1);
    push_item(FUNC_CMD, 2'd2, 16'd50);
    wait_results();
    write_reg(REG_BIT_PERIOD, 16'd1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_period = 1;
    settings_loaded++;
    push_item(FUNC_CMD, SEL_B, 16'd100);
    finish_frame();

    // One tick per bit for the directed frames below to keep them short.
    c = '{8'h5A, 8'h81, 8'h10, 8'h20, 8'h04, 8'h08, 7'd127, 16'd1};
    load_config(c);
    push_item(FUNC_CMD, SEL_A, 16'd0);
    push_ticks(5);
    // Commands on a busy line are dropped whatever the select.
    for (int s = 0; s < 4; s++) push_item(FUNC_CMD, 2'(s), 16'($urandom));
    finish_frame();
    // Rails and clamp edges on both motors, with no idling on either side.
    gaps_on = 1'b0;
    for (int i = 0; i < 4; i++) begin
      push_item(FUNC_CMD, (i % 2) ? SEL_B : SEL_A, corner_speeds[i]);
      finish_frame();
    end
    gaps_on = 1'b1;
    push_item(FUNC_CMD, 2'd3, 16'h7FFF);

    // Random settings: all zeros with a zero bit period, all ones with a bit
    // period of one, minimum nonzero speed scale.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c.start_byte = 8'($urandom);
      c.device_number = 8'($urandom);
      c.motor_a_code = 8'($urandom);
      c.motor_b_code = 8'($urandom);
      c.forward_code = 8'($urandom);
      c.reverse_code = 8'($urandom);
      c.max_speed_code = 7'($urandom_range(127));
      c.bit_period_ticks = 16'($urandom_range(1, 2));
      if (p == 0) c = '0;
      if (p == 1) c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd127, 16'd1};
      if (p == 2) c.max_speed_code = 7'd1;
      load_config(c);
      // pause the sender mid-phase once until every result is back
      run_phase(CMDS_PER_PHASE, (p == 2) ? 1 : -1);
    end

    // Slower bit period: see a few bit changes and a drop, then stop mid-frame.
    c.bit_period_ticks = 16'd12;
    gaps_on = 1'b0;
    load_config(c);
    push_item(FUNC_CMD, SEL_B, random_speed());
    push_ticks(30);
    push_item(FUNC_CMD, SEL_A, 16'd5);
    push_ticks(14);
    hold_input();

    // Drain, then keep the clock running for any stray result beat.
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d frames and %0d busy drops in %0d checked result beats,",
             frames_started, busy_drops, beats_checked);
    $display("over %0d register settings with bit periods from zero to twelve ticks.",
             settings_loaded);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
